[src/pgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgs_pkg
// shared widths, format codes, register indexes and stage types
// ----------------------------------------------------------------------------
package pgs_pkg;

	localparam int GAIN_FRAC_BITS = 24;
	localparam int SAMPLE_W       = 32;
	localparam int GAIN_W         = 32;
	localparam int PROD_W         = SAMPLE_W + GAIN_W;
	localparam int QUOT_W         = PROD_W - GAIN_FRAC_BITS;
	localparam int FMT_W          = 2;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 32;

	localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
	localparam logic [FMT_W-1:0] FMT_S16 = 2'd1;
	localparam logic [FMT_W-1:0] FMT_S24 = 2'd2;
	localparam logic [FMT_W-1:0] FMT_S32 = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'd1;

	localparam logic [FMT_W-1:0]  FORMAT_RESET = FMT_S16;
	localparam logic [GAIN_W-1:0] GAIN_UNITY   = GAIN_W'(64'd1 << GAIN_FRAC_BITS);

	localparam logic [7:0] U8_OFFSET = 8'h80;

	// signed 32-bit clamp limits, widened per use
	localparam logic signed [31:0] LIM8_LO  = -32'sd128;
	localparam logic signed [31:0] LIM8_HI  = 32'sd127;
	localparam logic signed [31:0] LIM16_LO = -32'sd32768;
	localparam logic signed [31:0] LIM16_HI = 32'sd32767;
	localparam logic signed [31:0] LIM32_LO = 32'sh8000_0000;
	localparam logic signed [31:0] LIM32_HI = 32'sh7FFF_FFFF;

	// side information that travels with each sample
	typedef struct packed {
		logic [FMT_W-1:0] fmt;
		logic             last;
	} meta_t;

endpackage

[src/pgs_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgs_in_if
// sample input channel: valid/ready plus raw container and buffer end mark
// ----------------------------------------------------------------------------
interface pgs_in_if;
	import pgs_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_in;
	logic                last_in;

	modport source (output valid, output sample_in, output last_in, input ready);
	modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

[src/pgs_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgs_out_if
// sample output channel: valid/ready plus scaled container and buffer end mark
// ----------------------------------------------------------------------------
interface pgs_out_if;
	import pgs_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_out;
	logic                last_out;

	modport source (output valid, output sample_out, output last_out, input ready);
	modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

[src/pgs_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgs_decode
// stage 1: turns the raw container into a signed 32-bit operand
// ----------------------------------------------------------------------------
module pgs_decode (
	input  logic                         clk,
	input  logic                         ld,
	input  logic [pgs_pkg::SAMPLE_W-1:0] raw,
	input  pgs_pkg::meta_t               meta,
	output logic signed [pgs_pkg::SAMPLE_W-1:0] x_s1,
	output pgs_pkg::meta_t               meta_s1
);
	import pgs_pkg::*;

	logic signed [SAMPLE_W-1:0] x_d;
	logic [7:0]                 u8_flip;

	assign u8_flip = raw[7:0] ^ U8_OFFSET;

	always_comb begin
		unique case (meta.fmt)
			FMT_U8:  x_d = $signed({{(SAMPLE_W-8){u8_flip[7]}}, u8_flip});
			FMT_S16: x_d = $signed({{(SAMPLE_W-16){raw[15]}}, raw[15:0]});
			// left-justify 24-bit samples
			FMT_S24: x_d = $signed({raw[23:0], 8'h00});
			default: x_d = $signed(raw);
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			x_s1    <= x_d;
			meta_s1 <= meta;
		end
	end
endmodule

[src/pgs_mult.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgs_mult
// stage 2: signed 32 x 32 product of sample and gain
// ----------------------------------------------------------------------------
module pgs_mult (
	input  logic                              clk,
	input  logic                              ld,
	input  logic signed [pgs_pkg::SAMPLE_W-1:0] x,
	input  logic signed [pgs_pkg::GAIN_W-1:0]   gain,
	input  pgs_pkg::meta_t                    meta,
	output logic signed [pgs_pkg::PROD_W-1:0] prod_s2,
	output pgs_pkg::meta_t                    meta_s2
);
	import pgs_pkg::*;

	logic signed [PROD_W-1:0] x_ext;
	logic signed [PROD_W-1:0] g_ext;

	assign x_ext = PROD_W'(x);
	assign g_ext = PROD_W'(gain);

	always_ff @(posedge clk) begin
		if (ld) begin
			prod_s2 <= x_ext * g_ext;
			meta_s2 <= meta;
		end
	end
endmodule

[src/pgs_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgs_round
// stage 3: drops the gain fraction bits, truncating toward zero
// ----------------------------------------------------------------------------
module pgs_round (
	input  logic                              clk,
	input  logic                              ld,
	input  logic signed [pgs_pkg::PROD_W-1:0] prod,
	input  pgs_pkg::meta_t                    meta,
	output logic signed [pgs_pkg::QUOT_W-1:0] quot_s3,
	output pgs_pkg::meta_t                    meta_s3
);
	import pgs_pkg::*;

	logic signed [QUOT_W-1:0] floor_q;
	logic                     bump;

	// floor division, then +1 for a negative product with a nonzero fraction
	assign floor_q = prod[PROD_W-1:GAIN_FRAC_BITS];
	assign bump    = prod[PROD_W-1] && (|prod[GAIN_FRAC_BITS-1:0]);

	always_ff @(posedge clk) begin
		if (ld) begin
			quot_s3 <= floor_q + $signed({{(QUOT_W-1){1'b0}}, bump});
			meta_s3 <= meta;
		end
	end
endmodule

[src/pgs_sat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgs_sat
// stage 4: clamps to the format range and re-encodes the container
// ----------------------------------------------------------------------------
module pgs_sat (
	input  logic                              clk,
	input  logic                              ld,
	input  logic signed [pgs_pkg::QUOT_W-1:0] quot,
	input  pgs_pkg::meta_t                    meta,
	output logic [pgs_pkg::SAMPLE_W-1:0]      sample_s4,
	output pgs_pkg::meta_t                    meta_s4
);
	import pgs_pkg::*;

	logic signed [31:0]       lo32;
	logic signed [31:0]       hi32;
	logic signed [QUOT_W-1:0] lo;
	logic signed [QUOT_W-1:0] hi;
	logic signed [QUOT_W-1:0] r;
	logic [SAMPLE_W-1:0]      enc;

	always_comb begin
		unique case (meta.fmt)
			FMT_U8: begin
				lo32 = LIM8_LO;
				hi32 = LIM8_HI;
			end
			FMT_S16: begin
				lo32 = LIM16_LO;
				hi32 = LIM16_HI;
			end
			default: begin
				lo32 = LIM32_LO;
				hi32 = LIM32_HI;
			end
		endcase
	end

	assign lo = $signed({{(QUOT_W-32){lo32[31]}}, lo32});
	assign hi = $signed({{(QUOT_W-32){hi32[31]}}, hi32});

	always_comb begin
		priority if (quot < lo) r = lo;
		else if (quot > hi)     r = hi;
		else                    r = quot;
	end

	always_comb begin
		unique case (meta.fmt)
			FMT_U8:  enc = {{(SAMPLE_W-8){1'b0}}, r[7:0] ^ U8_OFFSET};
			FMT_S16: enc = {{(SAMPLE_W-16){1'b0}}, r[15:0]};
			// back to 24 bits, arithmetic shift keeps the low 24 bits
			FMT_S24: enc = {8'h00, r[31:8]};
			default: enc = r[31:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			sample_s4 <= enc;
			meta_s4   <= meta;
		end
	end
endmodule

[src/pcm_gain_saturate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_gain_saturate
// scales pcm samples by a signed q8.24 gain and saturates to the format range
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  din      | in  | valid / ready      | sample_in[31:0], last_in
//  dout     | out | valid / ready      | sample_out[31:0], last_out
//  cfg      | in  | cfg_we (no ready)  | cfg_index[0], cfg_data[31:0]
//
// one request per cycle sustained while dout takes results; each sample
// passes the pipe stages decode, 32x32 multiply, fraction truncation, clamp
// and encode; dout.valid is the stage 4 valid bit, so an accepted sample
// is registered in stages 1 to 4 in turn before its result can leave
// arst_n clears all stage valid bits and loads format s16 and unity gain
// a stall on dout backs up stage by stage; a stage takes a new request
// whenever it is empty or its contents move on in the same cycle
// ----------------------------------------------------------------------------
module pcm_gain_saturate (
	input  logic                           clk,
	input  logic                           arst_n,
	pgs_in_if.sink                         din,
	pgs_out_if.source                      dout,
	input  logic                           cfg_we,
	input  logic [pgs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pgs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pgs_pkg::*;

	// configuration registers
	logic [FMT_W-1:0]         fmt_q;
	logic signed [GAIN_W-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= FORMAT_RESET;
			gain_q <= GAIN_UNITY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMAT: fmt_q  <= cfg_data[FMT_W-1:0];
				default:    gain_q <= $signed(cfg_data[GAIN_W-1:0]);
			endcase
		end
	end

	// stage valid bits and per-stage ready
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic ld1, ld2, ld3, ld4;

	assign rdy4 = !v_s4 || dout.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	// a stage loads when it can take data and the one before holds some
	assign ld1 = rdy1 && din.valid;
	assign ld2 = rdy2 && v_s1;
	assign ld3 = rdy3 && v_s2;
	assign ld4 = rdy4 && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= din.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	assign din.ready = rdy1;

	// format is captured with each sample so it follows the data down the pipe
	meta_t                    meta_in;
	meta_t                    meta_s1, meta_s2, meta_s3, meta_s4;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [QUOT_W-1:0]   quot_s3;
	logic [SAMPLE_W-1:0]        sample_s4;

	assign meta_in.fmt  = fmt_q;
	assign meta_in.last = din.last_in;

	pgs_decode u_decode (
		.clk     (clk),
		.ld      (ld1),
		.raw     (din.sample_in),
		.meta    (meta_in),
		.x_s1    (x_s1),
		.meta_s1 (meta_s1)
	);

	pgs_mult u_mult (
		.clk     (clk),
		.ld      (ld2),
		.x       (x_s1),
		.gain    (gain_q),
		.meta    (meta_s1),
		.prod_s2 (prod_s2),
		.meta_s2 (meta_s2)
	);

	pgs_round u_round (
		.clk     (clk),
		.ld      (ld3),
		.prod    (prod_s2),
		.meta    (meta_s2),
		.quot_s3 (quot_s3),
		.meta_s3 (meta_s3)
	);

	pgs_sat u_sat (
		.clk       (clk),
		.ld        (ld4),
		.quot      (quot_s3),
		.meta      (meta_s3),
		.sample_s4 (sample_s4),
		.meta_s4   (meta_s4)
	);

	assign dout.valid      = v_s4;
	assign dout.sample_out = sample_s4;
	assign dout.last_out   = meta_s4.last;

	// an accepted request always lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(din.valid && din.ready) |=> v_s1)
		else $error("accepted request did not reach stage 1");

	// a stage 3 entry that cannot move on must stay put
	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !ld4) |=> v_s3)
		else $error("stalled stage 3 entry was dropped");

	// 8-bit results leave the upper container bits at zero
	a_u8_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && meta_s4.fmt == FMT_U8) |-> (sample_s4[SAMPLE_W-1:8] == '0))
		else $error("8-bit result has upper bits set");

	// 24-bit results leave the top byte at zero
	a_s24_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && meta_s4.fmt == FMT_S24) |-> (sample_s4[SAMPLE_W-1:24] == '0))
		else $error("24-bit result has top byte set");
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for pcm_gain_saturate: a queue-fed driver offers raw
// sample containers, a monitor predicts each scaled and clamped sample at
// input acceptance and checks the outputs in order. Runs a short directed
// pass per format, then random phases over all formats and gain extremes
// with sender gaps, receiver stalls and one long output hold-off
// ----------------------------------------------------------------------------
module tb_top;
	import pgs_pkg::*;

	// one raw or scaled sample with its buffer end mark
	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} pcm_item_t;

	localparam int SETTLE_CYCLES   = 8;       // pipe is four deep, leave margin
	localparam int HOLD_CYCLES     = 400;     // long output hold-off
	localparam int CYCLE_LIMIT     = 300000;
	localparam int RANDOM_PHASES   = 16;
	localparam int PHASE_ITEMS     = 115;

	// gains that the random phases walk through, then two random kinds
	localparam logic [GAIN_W-1:0] FIXED_GAINS [6] = '{
		GAIN_UNITY,       // unity
		32'h8000_0000,    // most negative: -128.0
		32'h7FFF_FFFF,    // most positive: just under +128.0
		32'h0000_0000,    // mute
		32'hFF00_0000,    // -1.0, inverts
		32'h0280_0000     // 2.5
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pgs_in_if  din_if ();
	pgs_out_if dout_if ();

	pcm_gain_saturate u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din_if),
		.dout      (dout_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// raw samples waiting to be offered, and scaled samples owed by the block
	pcm_item_t raw_samples[$];
	pcm_item_t scaled_expected[$];

	// shadow copy of the two registers as last written
	logic [FMT_W-1:0]         cur_fmt;
	logic signed [GAIN_W-1:0] cur_gain;

	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	logic        hold_req;
	int          hold_left;

	int samples_sent;
	int results_seen;
	int err_count;
	int cycle_count;

	// ------------------------------------------------------------------------
	// prediction: sign-extend per format, exact 64-bit product, drop the
	// fraction bits toward zero, clamp, then re-encode into the container
	// ------------------------------------------------------------------------
	function automatic logic [SAMPLE_W-1:0] apply_gain(
		input logic [FMT_W-1:0]         fmt,
		input logic signed [GAIN_W-1:0] gain,
		input logic [SAMPLE_W-1:0]      raw
	);
		longint      x;
		longint      prod;
		longint      q;
		longint      lo;
		longint      hi;
		logic [63:0] mag;
		logic [63:0] qv;
		case (fmt)
			FMT_U8: begin
				// offset-binary: flip the msb to get two's complement
				x  = longint'($signed(raw[7:0] ^ U8_OFFSET));
				lo = longint'(LIM8_LO);
				hi = longint'(LIM8_HI);
			end
			FMT_S16: begin
				x  = longint'($signed(raw[15:0]));
				lo = longint'(LIM16_LO);
				hi = longint'(LIM16_HI);
			end
			FMT_S24: begin
				// left-justified into 32 bits before scaling
				x  = longint'($signed(raw[23:0])) * 256;
				lo = longint'(LIM32_LO);
				hi = longint'(LIM32_HI);
			end
			default: begin
				x  = longint'($signed(raw));
				lo = longint'(LIM32_LO);
				hi = longint'(LIM32_HI);
			end
		endcase
		prod = x * longint'(gain);
		// truncate toward zero, not toward minus infinity
		mag  = (prod < 0) ? 64'(-prod) : 64'(prod);
		q    = longint'(mag >> GAIN_FRAC_BITS);
		if (prod < 0)
			q = -q;
		if (q < lo)
			q = lo;
		else if (q > hi)
			q = hi;
		qv = 64'(q);
		case (fmt)
			FMT_U8:  apply_gain = {24'd0, qv[7:0] ^ U8_OFFSET};
			FMT_S16: apply_gain = {16'd0, qv[15:0]};
			// arithmetic shift back by 8, kept in the low 24 bits
			FMT_S24: apply_gain = {8'd0, qv[31:8]};
			default: apply_gain = qv[31:0];
		endcase
	endfunction

	// random container: full-range or close to zero most often, some near the
	// format limits; bits above the format stay random
	function automatic logic [SAMPLE_W-1:0] random_sample(input logic [FMT_W-1:0] fmt);
		logic [SAMPLE_W-1:0] r;
		logic [31:0]         near_zero;
		int unsigned         pick;
		int unsigned         k;
		logic                top;
		r         = $urandom;
		pick      = $urandom_range(9);
		k         = $urandom_range(3);
		top       = $urandom_range(1);
		near_zero = 32'($urandom_range(511)) - 32'd256;
		if (pick >= 4 && pick < 6) begin
			case (fmt)
				FMT_U8:  r[7:0]  = top ? 8'(8'hFF - k) : 8'(k);
				FMT_S16: r[15:0] = top ? 16'(16'h7FFF - k) : 16'(16'h8000 + k);
				FMT_S24: r[23:0] = top ? 24'(24'h7F_FFFF - k) : 24'(24'h80_0000 + k);
				default: r       = top ? 32'(32'h7FFF_FFFF - k) : 32'(32'h8000_0000 + k);
			endcase
		end else if (pick >= 6) begin
			case (fmt)
				FMT_U8:  r[7:0]  = U8_OFFSET + near_zero[7:0];
				FMT_S16: r[15:0] = near_zero[15:0];
				FMT_S24: r[23:0] = near_zero[23:0];
				default: r       = near_zero;
			endcase
		end
		random_sample = r;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	// ------------------------------------------------------------------------
	// clock and cycle limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// driver: offers the next raw sample once the current request is taken
	// or nothing is on offer; random gaps per src_idle_pct
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drv
		pcm_item_t nxt;
		if (!arst_n) begin
			din_if.valid     <= 1'b0;
			din_if.sample_in <= '0;
			din_if.last_in   <= 1'b0;
		end else if (!din_if.valid || din_if.ready) begin
			if (raw_samples.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				nxt               = raw_samples.pop_front();
				din_if.valid     <= 1'b1;
				din_if.sample_in <= nxt.sample;
				din_if.last_in   <= nxt.last;
			end else begin
				din_if.valid <= 1'b0;
			end
		end
	end

	// long hold-off counter, kicked by the stimulus process
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_req)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// receiver: random stalls, or held low during the hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dout_if.ready <= 1'b0;
		else if (hold_req || hold_left != 0)
			dout_if.ready <= 1'b0;
		else
			dout_if.ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// ------------------------------------------------------------------------
	// monitor: predict at each input request, check each output request
	// against the oldest prediction; push before pop keeps order fixed
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : mon
		pcm_item_t owed;
		pcm_item_t want;
		if (arst_n) begin
			if (din_if.valid && din_if.ready) begin
				owed.sample = apply_gain(cur_fmt, cur_gain, din_if.sample_in);
				owed.last   = din_if.last_in;
				scaled_expected.push_back(owed);
			end
			if (dout_if.valid && dout_if.ready) begin
				results_seen++;
				if (scaled_expected.size() == 0) begin
					flag_mismatch("result with nothing owed", dout_if.sample_out, '0);
				end else begin
					want = scaled_expected.pop_front();
					if (dout_if.sample_out !== want.sample)
						flag_mismatch("sample_out", dout_if.sample_out, want.sample);
					if (dout_if.last_out !== want.last)
						flag_mismatch("last_out", 32'(dout_if.last_out), 32'(want.last));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic stream(input logic [SAMPLE_W-1:0] raw, input logic last);
		pcm_item_t item;
		item.sample = raw;
		item.last   = last;
		raw_samples.push_back(item);
		samples_sent++;
	endtask

	// every queued sample has come out; then let the pipe settle
	task automatic drain();
		while (results_seen < samples_sent)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FORMAT)
			cur_fmt = value[FMT_W-1:0];
		else
			cur_gain = value;
	endtask

	// registers only change with the block empty
	task automatic set_config(input logic [FMT_W-1:0] fmt, input logic [GAIN_W-1:0] gain);
		drain();
		write_reg(REG_FORMAT, CFG_DATA_W'(fmt));
		write_reg(REG_GAIN, gain);
	endtask

	task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
		@(posedge clk);
		src_idle_pct   <= src_pct;
		sink_stall_pct <= sink_pct;
	endtask

	initial begin : stim
		int                  p;
		int                  i;
		logic [FMT_W-1:0]    fmt;
		logic [GAIN_W-1:0]   gain;
		// known values from time zero, reset held low before release
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		hold_req         = 1'b0;
		src_idle_pct     = 0;
		sink_stall_pct   = 0;
		cur_fmt          = FORMAT_RESET;
		cur_gain         = GAIN_UNITY;
		samples_sent     = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: signed 16-bit at unity, high container bits ignored
		stream(32'h0000_0000, 1'b0);
		stream(32'hFFFF_7FFF, 1'b1);
		stream(32'h0000_8000, 1'b0);
		stream(32'hFFFF_FFFF, 1'b0);
		stream(32'h1234_0001, 1'b1);

		// offset-binary 8-bit at 2.5: both rails saturate, 0x80 is zero
		set_config(FMT_U8, 32'h0280_0000);
		stream(32'h0000_0000, 1'b0);
		stream(32'h0000_00FF, 1'b0);
		stream(32'h0000_0080, 1'b1);
		stream(32'hFFFF_FF81, 1'b0);
		stream(32'h0000_007F, 1'b0);

		// 24-bit inverted: most negative sample overflows to the top rail
		set_config(FMT_S24, 32'hFF00_0000);
		stream(32'h0080_0000, 1'b0);
		stream(32'h007F_FFFF, 1'b0);
		stream(32'hFF00_0001, 1'b1);
		stream(32'h00FF_FFFF, 1'b0);
		stream(32'h0000_0000, 1'b0);

		// 32-bit at the most negative gain: saturation both ways
		set_config(FMT_S32, 32'h8000_0000);
		stream(32'h8000_0000, 1'b0);
		stream(32'h7FFF_FFFF, 1'b0);
		stream(32'h0000_0001, 1'b1);
		stream(32'hFFFF_FFFF, 1'b0);

		// half gain: odd values truncate toward zero on both signs
		set_config(FMT_S32, 32'h0080_0000);
		stream(32'h0000_0003, 1'b0);
		stream(32'hFFFF_FFFD, 1'b1);

		// random phases: format and gain walk together, idling rotates
		for (p = 0; p < RANDOM_PHASES; p++) begin
			fmt = FMT_W'((p + p / 4) % 4);
			if (p % 8 < 6)
				gain = FIXED_GAINS[p % 8];
			else if (p % 8 == 6)
				gain = 32'($urandom_range(32'h0800_0000)) - 32'h0400_0000;
			else
				gain = $urandom;
			set_config(fmt, gain);
			case (p % 4)
				0: set_idling(0, 0);
				1: set_idling(63, 0);
				2: set_idling(0, 63);
				default: set_idling(21, 21);
			endcase
			for (i = 0; i < PHASE_ITEMS; i++)
				stream(random_sample(fmt), $urandom_range(7) == 0);
			// one phase at full input rate with the output held off so the
			// pipe fills and back-pressures the sender
			if (p == 4) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
		end

		drain();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (scaled_expected.size() != 0)
			flag_mismatch("results still owed", 32'(scaled_expected.size()), 32'd0);
		if (err_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
